// ----- rtl/fsa_pkg.sv -----
// Shared types and codes for the free segment allocator.
// No dependencies; used by fsa_ctrl and free_segment_allocator_top under rtl/.
`default_nettype none

package fsa_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDR_BITS_DEF     = 32;

  // One table entry holds a start address and a length.
  localparam int FIELD_W = 32;
  localparam int ENTRY_W = 2 * FIELD_W;

  // Fit policies.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;

  // Request functions.
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] granted;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/fsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/fsa_ctrl.sv -----
// Sequencer of the free segment allocator: table scan, decision, entry shifts.
// Depends on fsa_pkg; drives the table RAM ports.
`default_nettype none

module fsa_ctrl #(
  parameter int TABLE_ENTRIES = fsa_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = fsa_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [1:0]                        fit_policy,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire logic                              req_func,
  input  wire logic [fsa_pkg::FIELD_W-1:0]       req_size,
  input  wire logic [fsa_pkg::FIELD_W-1:0]       req_addr,
  output logic                                   res_valid,
  input  wire logic                              res_take,
  output fsa_pkg::result_t                       res,
  output logic                                   ram_we,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       ram_waddr,
  output logic [fsa_pkg::ENTRY_W-1:0]            ram_wdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       ram_raddr,
  input  wire logic [fsa_pkg::ENTRY_W-1:0]       ram_rdata
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int FW = fsa_pkg::FIELD_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);
  localparam logic [FW:0] ADDR_LIMIT =
    (ADDR_BITS >= FW) ? {1'b0, {FW{1'b1}}} : ((FW+1)'(1) << ADDR_BITS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] cursor_r, cursor_nxt;

  // Request held for the whole operation.
  logic          func_r;
  logic [FW-1:0] size_r, addr_r;
  logic [FW:0]   end_r;

  // Scan pipeline.
  logic [CW-1:0] scan_rd_r;
  logic          rvld_r;
  logic [IW-1:0] ridx_r;

  // Allocation candidates: first (under best fit, smallest) overall hit and first hit at or after the cursor.
  logic          hit_r, ge_r;
  logic [IW-1:0] hit_idx_r, ge_idx_r;
  logic [FW-1:0] hit_start_r, hit_len_r, ge_start_r, ge_len_r;

  // Free insertion point and its neighbours.
  logic          ovl_r, nx_vld_r;
  logic [CW-1:0] p_r;
  logic [FW-1:0] pv_start_r, pv_len_r, nx_start_r, nx_len_r;

  // Single entry write and shift plan.
  logic          wr_pend_r, up_r, pend_r;
  logic [IW-1:0] w_idx_r, pend_addr_r;
  logic [FW-1:0] w_start_r, w_len_r;
  logic [CW-1:0] mv_rd_r, mv_rem_r;

  fsa_pkg::result_t res_r;

  logic [FW-1:0] e_start, e_len;
  logic [FW:0]   e_end;
  logic          e_fits;
  logic [IW-1:0] cur_eff;

  assign e_start = ram_rdata[fsa_pkg::ENTRY_W-1:FW];
  assign e_len   = ram_rdata[FW-1:0];
  assign e_end   = {1'b0, e_start} + {1'b0, e_len};
  assign e_fits  = e_len >= size_r;
  assign cur_eff = ({{(CW-IW){1'b0}}, cursor_r} < count_r) ? cursor_r : '0;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Decision after the scan: selected segment and neighbour tests.
  logic          sel_ok;
  logic [IW-1:0] sel_idx;
  logic [FW-1:0] sel_start, sel_len;
  logic          prev_ok, next_ok;
  logic [CW-1:0] p_m1, p_p1, cnt_m1;

  always_comb begin
    if (fit_policy == fsa_pkg::POL_NEXT && ge_r) begin
      sel_ok = 1'b1;  sel_idx = ge_idx_r;  sel_start = ge_start_r;  sel_len = ge_len_r;
    end else begin
      sel_ok = hit_r; sel_idx = hit_idx_r; sel_start = hit_start_r; sel_len = hit_len_r;
    end
    p_m1    = p_r - CW'(1);
    p_p1    = p_r + CW'(1);
    cnt_m1  = count_r - CW'(1);
    prev_ok = (p_r != '0) && (({1'b0, pv_start_r} + {1'b0, pv_len_r}) == {1'b0, addr_r});
    next_ok = nx_vld_r && (end_r == {1'b0, nx_start_r});
  end

  // Next state and table control.
  logic [IW-1:0] c_tmp;
  logic [CW-1:0] sel_w;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    ram_we     = 1'b0;
    ram_waddr  = w_idx_r;
    ram_wdata  = {w_start_r, w_len_r};
    ram_raddr  = scan_rd_r[IW-1:0];
    c_tmp      = cursor_r;
    sel_w      = {{(CW-IW){1'b0}}, sel_idx};
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          state_nxt = S_SCAN;
          if (req_size == '0 ||
              (req_func == fsa_pkg::FN_FREE &&
               ({1'b0, req_addr} + {1'b0, req_size}) > ADDR_LIMIT)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_rd_r == count_r && !rvld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (func_r == fsa_pkg::FN_ALLOC) begin
          if (sel_ok) begin
            if (fit_policy == fsa_pkg::POL_NEXT) begin
              c_tmp = sel_idx;
            end
            if (sel_len == size_r) begin
              count_nxt = cnt_m1;
              if (c_tmp > sel_idx) begin
                c_tmp = c_tmp - IW'(1);
              end
              state_nxt = (cnt_m1 != sel_w) ? S_MOVE : S_DONE;
            end else begin
              state_nxt = S_WRITE;
            end
            cursor_nxt = ({{(CW-IW){1'b0}}, c_tmp} >= count_nxt) ? '0 : c_tmp;
          end
        end else if (!ovl_r) begin
          if (prev_ok && next_ok) begin
            if (cursor_r == p_r[IW-1:0]) begin
              c_tmp = p_m1[IW-1:0];
            end
            if ({{(CW-IW){1'b0}}, c_tmp} > p_r) begin
              c_tmp = c_tmp - IW'(1);
            end
            count_nxt  = cnt_m1;
            cursor_nxt = ({{(CW-IW){1'b0}}, c_tmp} >= cnt_m1) ? '0 : c_tmp;
            state_nxt  = S_WRITE;
          end else if (prev_ok || next_ok) begin
            state_nxt = S_WRITE;
          end else if (count_r != FULL_CNT) begin
            if (p_r < count_r && {{(CW-IW){1'b0}}, cursor_r} >= p_r) begin
              c_tmp = cursor_r + IW'(1);
            end
            count_nxt  = count_r + CW'(1);
            cursor_nxt = ({{(CW-IW){1'b0}}, c_tmp} >= count_nxt) ? '0 : c_tmp;
            state_nxt  = (count_r != p_r) ? S_MOVE : S_WRITE;
          end
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        state_nxt = (!up_r && mv_rem_r != '0) ? S_MOVE : S_DONE;
      end
      S_MOVE: begin
        ram_raddr = mv_rd_r[IW-1:0];
        ram_we    = pend_r;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
        if (mv_rem_r == '0 && !pend_r) begin
          state_nxt = up_r ? S_WRITE : S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      rvld_r   <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      rvld_r   <= (state_r == S_SCAN) && (scan_rd_r != count_r);
      pend_r   <= (state_r == S_MOVE) && (mv_rem_r != '0);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ridx_r      <= scan_rd_r[IW-1:0];
    pend_addr_r <= up_r ? (mv_rd_r[IW-1:0] + IW'(1)) : (mv_rd_r[IW-1:0] - IW'(1));
    case (state_r)
      S_IDLE: begin
        func_r      <= req_func;
        size_r      <= req_size;
        addr_r      <= req_addr;
        end_r       <= {1'b0, req_addr} + {1'b0, req_size};
        scan_rd_r   <= '0;
        hit_r       <= 1'b0;
        ge_r        <= 1'b0;
        ovl_r       <= 1'b0;
        nx_vld_r    <= 1'b0;
        p_r         <= '0;
        up_r        <= 1'b0;
        mv_rem_r    <= '0;
        res_r.granted <= '0;
        res_r.status  <= (req_size == '0) ? fsa_pkg::ST_ZERO : fsa_pkg::ST_NOFIT;
      end
      S_SCAN: begin
        if (scan_rd_r != count_r) begin
          scan_rd_r <= scan_rd_r + CW'(1);
        end
        if (rvld_r) begin
          if (func_r == fsa_pkg::FN_ALLOC) begin
            if (e_fits && (!hit_r ||
                (fit_policy == fsa_pkg::POL_BEST && e_len < hit_len_r))) begin
              hit_r <= 1'b1; hit_idx_r <= ridx_r;
              hit_start_r <= e_start; hit_len_r <= e_len;
            end
            if (e_fits && !ge_r && ridx_r >= cur_eff) begin
              ge_r <= 1'b1; ge_idx_r <= ridx_r;
              ge_start_r <= e_start; ge_len_r <= e_len;
            end
          end else begin
            if ({1'b0, e_start} < end_r && {1'b0, addr_r} < e_end) begin
              ovl_r <= 1'b1;
            end
            if (e_start < addr_r) begin
              p_r <= {{(CW-IW){1'b0}}, ridx_r} + CW'(1);
              pv_start_r <= e_start; pv_len_r <= e_len;
            end else if (!nx_vld_r) begin
              nx_vld_r <= 1'b1;
              nx_start_r <= e_start; nx_len_r <= e_len;
            end
          end
        end
      end
      S_DECIDE: begin
        if (func_r == fsa_pkg::FN_ALLOC) begin
          if (sel_ok) begin
            res_r.status  <= fsa_pkg::ST_OK;
            res_r.granted <= sel_start;
            w_idx_r   <= sel_idx;
            w_start_r <= sel_start + size_r;
            w_len_r   <= sel_len - size_r;
            mv_rd_r   <= sel_w + CW'(1);
            mv_rem_r  <= (sel_len == size_r) ? (cnt_m1 - sel_w) : '0;
          end
        end else if (!ovl_r) begin
          res_r.status <= fsa_pkg::ST_OK;
          if (prev_ok && next_ok) begin
            w_idx_r   <= p_m1[IW-1:0];
            w_start_r <= pv_start_r;
            w_len_r   <= pv_len_r + size_r + nx_len_r;
            mv_rd_r   <= p_p1;
            mv_rem_r  <= cnt_m1 - p_r;
          end else if (prev_ok) begin
            w_idx_r   <= p_m1[IW-1:0];
            w_start_r <= pv_start_r;
            w_len_r   <= pv_len_r + size_r;
          end else if (next_ok) begin
            w_idx_r   <= p_r[IW-1:0];
            w_start_r <= addr_r;
            w_len_r   <= nx_len_r + size_r;
          end else if (count_r != FULL_CNT) begin
            w_idx_r   <= p_r[IW-1:0];
            w_start_r <= addr_r;
            w_len_r   <= size_r;
            up_r      <= 1'b1;
            mv_rd_r   <= cnt_m1;
            mv_rem_r  <= count_r - p_r;
          end else begin
            res_r.status <= fsa_pkg::ST_FULL;
          end
        end
      end
      S_MOVE: begin
        if (mv_rem_r != '0) begin
          mv_rem_r <= mv_rem_r - CW'(1);
          mv_rd_r  <= up_r ? (mv_rd_r - CW'(1)) : (mv_rd_r + CW'(1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/free_segment_allocator_top.sv -----
// Free segment allocator: a request scans every table entry, then on an insert
// or removal shifts the later entries one at a time; the single read port of
// the table RAM sets this.
// One request is in work at a time; the result waits in an output register.
// Synchronous active-low reset empties the table, zeroes the cursor and the
// policy register; the table RAM itself is not cleared.
// Top level: holds the policy register, result register, table RAM and sequencer.
// Depends on fsa_pkg, fsa_ram and fsa_ctrl.
`default_nettype none

module free_segment_allocator_top #(
  parameter int TABLE_ENTRIES = fsa_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = fsa_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic [fsa_pkg::FIELD_W-1:0] in_request_size,
  input  wire logic [fsa_pkg::FIELD_W-1:0] in_free_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [fsa_pkg::FIELD_W-1:0]      out_granted_address
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  logic [1:0]  fit_policy_r;
  logic        req_ready, res_valid, res_take;
  fsa_pkg::result_t res;
  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr, ram_raddr;
  logic [fsa_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic                          out_valid_r;
  fsa_pkg::result_t              out_r;

  assign in_stall            = !req_ready;
  assign res_take            = res_valid && (!out_valid_r || !out_stall);
  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_granted_address = out_r.granted;

  // Policy register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= fsa_pkg::POL_FIRST;
    end else if (cfg_we) begin
      fit_policy_r <= cfg_wdata;
    end
  end

  // Result register toward the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  // Segment table.
  fsa_ram #(
    .WIDTH(fsa_pkg::ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer.
  fsa_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fit_policy(fit_policy_r),
    .req_valid (in_valid),
    .req_ready (req_ready),
    .req_func  (in_func),
    .req_size  (in_request_size),
    .req_addr  (in_free_address),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // A failed request never grants an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fsa_pkg::ST_OK |-> out_granted_address == '0)
    else $error("failed request carries an address");

  // Once a request is taken the block is busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while busy");

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for free_segment_allocator_top: random and directed
// allocate and free requests, checked against a behavioral free-list model.
// Depends on fsa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;

  localparam int NSEG = fsa_pkg::TABLE_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        func;
    logic [31:0] size;
    logic [31:0] addr;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_request_size;
  logic [31:0] in_free_address;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_granted_address;

  free_segment_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_request_size(in_request_size), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_granted_address(out_granted_address)
  );

  // Model of the free-segment table.
  logic [31:0] seg_start[NSEG];
  logic [31:0] seg_len[NSEG];
  int          seg_cnt;
  int          cursor;
  logic [1:0]  policy;

  request_t          pending_reqs[$];
  fsa_pkg::result_t  expected_results[$];
  int          failures;
  int          idle_cycles;
  bit          quiet_phase;
  bit          hold_sender;
  bit          tb_done;

  // Queues for tracking allocations; nothing in the bench fills or reads them.
  logic [31:0] held_addr[$];
  logic [31:0] held_size[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void remove_seg(int i);
    for (int k = i; k < seg_cnt - 1; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_len[k]   = seg_len[k+1];
    end
    seg_cnt--;
    if (cursor > i) cursor--;
    if (cursor >= seg_cnt) cursor = 0;
  endfunction

  function automatic void insert_seg(int p, logic [31:0] s, logic [31:0] l);
    for (int k = seg_cnt; k > p; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_len[k]   = seg_len[k-1];
    end
    if (p < seg_cnt && cursor >= p) cursor++;
    seg_start[p] = s;
    seg_len[p]   = l;
    seg_cnt++;
    if (cursor >= seg_cnt) cursor = 0;
  endfunction

  function automatic int choose_seg(logic [31:0] size);
    int best;
    int i;
    best = -1;
    if (policy == fsa_pkg::POL_BEST) begin
      for (i = 0; i < seg_cnt; i++)
        if (seg_len[i] >= size && (best < 0 || seg_len[i] < seg_len[best])) best = i;
      return best;
    end
    if (policy == fsa_pkg::POL_NEXT) begin
      for (int k = 0; k < seg_cnt; k++) begin
        i = (cursor < seg_cnt ? cursor : 0) + k;
        if (i >= seg_cnt) i -= seg_cnt;
        if (seg_len[i] >= size) return i;
      end
      return -1;
    end
    for (i = 0; i < seg_cnt; i++)
      if (seg_len[i] >= size) return i;
    return -1;
  endfunction

  // Applies one request to the table and returns the result it should give.
  function automatic fsa_pkg::result_t allocate_or_free(request_t r);
    fsa_pkg::result_t res;
    int          sel;
    int          p;
    bit          prev_ok;
    bit          next_ok;
    logic [32:0] fin;
    res = '{status: fsa_pkg::ST_OK, granted: '0};
    if (r.size == 0) begin
      res.status = fsa_pkg::ST_ZERO;
      return res;
    end
    if (r.func == fsa_pkg::FN_ALLOC) begin
      sel = choose_seg(r.size);
      if (sel < 0) begin
        res.status = fsa_pkg::ST_NOFIT;
        return res;
      end
      res.granted = seg_start[sel];
      if (policy == fsa_pkg::POL_NEXT) cursor = sel;
      if (seg_len[sel] == r.size) remove_seg(sel);
      else begin
        seg_start[sel] += r.size;
        seg_len[sel]   -= r.size;
      end
      return res;
    end
    fin = {1'b0, r.addr} + r.size;
    if (fin > 33'hFFFF_FFFF) begin
      res.status = fsa_pkg::ST_NOFIT;
      return res;
    end
    p = 0;
    for (int i = 0; i < seg_cnt; i++) begin
      if ({1'b0, seg_start[i]} < fin && {1'b0, r.addr} < {1'b0, seg_start[i]} + seg_len[i])
      begin
        res.status = fsa_pkg::ST_NOFIT;
        return res;
      end
      if (seg_start[i] < r.addr) p = i + 1;
    end
    prev_ok = p > 0 && ({1'b0, seg_start[p-1]} + seg_len[p-1]) == {1'b0, r.addr};
    next_ok = p < seg_cnt && fin == {1'b0, seg_start[p]};
    if (prev_ok && next_ok) begin
      seg_len[p-1] = seg_len[p-1] + r.size + seg_len[p];
      if (cursor == p) cursor = p - 1;
      remove_seg(p);
    end else if (prev_ok) begin
      seg_len[p-1] += r.size;
    end else if (next_ok) begin
      seg_start[p] = r.addr;
      seg_len[p]  += r.size;
    end else if (seg_cnt >= NSEG) begin
      res.status = fsa_pkg::ST_FULL;
    end else begin
      insert_seg(p, r.addr, r.size);
    end
    return res;
  endfunction

  task automatic queue_request(logic f, logic [31:0] s, logic [31:0] a);
    pending_reqs.push_back('{func: f, size: s, addr: a});
  endtask

  // Waits for every queued request to be accepted and every result to arrive.
  task automatic drain;
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (2 * NSEG + 20) @(posedge clk);
  endtask

  task automatic set_policy(logic [1:0] p);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we    <= 1'b0;
    policy = p;
  endtask

  // Random sequence: allocations of small sizes, frees of small blocks at random
  // addresses, zero sizes, plus occasional wild requests.
  task automatic queue_random(int n);
    int          k;
    int          j;
    logic [31:0] a;
    logic [31:0] s;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        queue_request(fsa_pkg::FN_ALLOC, $urandom_range(1, 64), $urandom);
      end else if (k < 75) begin
        queue_request(fsa_pkg::FN_FREE, $urandom_range(1, 48), $urandom_range(0, 4095) * 64);
      end else if (k < 88) begin
        a = $urandom_range(0, 8191);
        s = $urandom_range(1, 32);
        queue_request(fsa_pkg::FN_FREE, s, a);
      end else if (k < 93) begin
        queue_request(1'($urandom_range(0, 1)), 32'd0, $urandom);
      end else begin
        s = $urandom;
        a = $urandom;
        j = $urandom_range(0, 1);
        queue_request(j[0], s, a);
      end
    end
  endtask

  bit accepted_in;
  always @(posedge clk) begin
    accepted_in <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(allocate_or_free('{func: in_func, size: in_request_size,
                                                     addr: in_free_address}));
      void'(pending_reqs.pop_front());
    end
  end

  // Driver: presents queued requests at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accepted_in) begin
      if (pending_reqs.size() != 0 && !hold_sender &&
          (quiet_phase || $urandom_range(0, 99) >= 34)) begin
        in_valid        <= 1'b1;
        in_func         <= pending_reqs[0].func;
        in_request_size <= pending_reqs[0].size;
        in_free_address <= pending_reqs[0].addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !quiet_phase && $urandom_range(0, 99) < 34;
  end

  // Monitor: checks results against the oldest expectation.
  always @(posedge clk) begin
    fsa_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d granted=%h", $time, out_status,
                 out_granted_address);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          failures++;
        end
        if (out_granted_address !== want.granted) begin
          $display("%0t: granted_address expected %h actual %h", $time, want.granted,
                   out_granted_address);
          failures++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || tb_done || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else if (expected_results.size() != 0 || pending_reqs.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("free_segment_allocator_top test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_request_size = '0;
    in_free_address = '0;
    out_stall = 1'b0;
    failures = 0;
    idle_cycles = 0;
    quiet_phase = 1'b0;
    hold_sender = 1'b0;
    tb_done = 1'b0;
    seg_cnt = 0;
    cursor = 0;
    policy = fsa_pkg::POL_FIRST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, zero sizes, extremes, merges, overflow of the space.
    queue_request(fsa_pkg::FN_ALLOC, 32'd1, 32'hFFFF_FFFF);
    queue_request(fsa_pkg::FN_FREE, 32'd0, 32'd100);
    queue_request(fsa_pkg::FN_ALLOC, 32'd0, 32'd0);
    queue_request(fsa_pkg::FN_FREE, 32'd100, 32'd1000);
    queue_request(fsa_pkg::FN_FREE, 32'd100, 32'd800);
    queue_request(fsa_pkg::FN_FREE, 32'd100, 32'd1200);
    queue_request(fsa_pkg::FN_FREE, 32'd100, 32'd1100);
    queue_request(fsa_pkg::FN_FREE, 32'd100, 32'd900);
    queue_request(fsa_pkg::FN_FREE, 32'd50, 32'd950);
    queue_request(fsa_pkg::FN_FREE, 32'h0000_0010, 32'hFFFF_FFF0);
    queue_request(fsa_pkg::FN_FREE, 32'h0000_000F, 32'hFFFF_FFF0);
    queue_request(fsa_pkg::FN_FREE, 32'hFFFF_FFFF, 32'd0);
    queue_request(fsa_pkg::FN_ALLOC, 32'hFFFF_FFFF, 32'd0);
    queue_request(fsa_pkg::FN_ALLOC, 32'd500, 32'd0);
    queue_request(fsa_pkg::FN_ALLOC, 32'd15, 32'd0);
    queue_request(fsa_pkg::FN_FREE, 32'd10, 32'd0);
    queue_request(fsa_pkg::FN_ALLOC, 32'd10, 32'hFFFF_FFFF);
    drain();

    // Sender held back while two requests are queued, then released.
    hold_sender = 1'b1;
    queue_request(fsa_pkg::FN_FREE, 32'd7, 32'd5000);
    queue_request(fsa_pkg::FN_FREE, 32'd3, 32'd4000);
    repeat (10) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    // Fill the table to check the full status, then each policy.
    for (int i = 0; i < NSEG + 2; i++)
      queue_request(fsa_pkg::FN_FREE, 32'd2, 32'h0010_0000 + 8 * i);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_policy(p[1:0]);
      quiet_phase = (p == 1);
      queue_random(160);
      drain();
    end
    set_policy(fsa_pkg::POL_NEXT);
    queue_random(60);
    drain();
    quiet_phase = 1'b0;
    tb_done = 1'b1;
    if (failures == 0)
      $display("free_segment_allocator_top test passed");
    else
      $display("free_segment_allocator_top test failed");
    $finish;
  end

endmodule
